// ===== rtl/kslot_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kslot_pkg;

  // Request kinds carried in s_tuser.
  localparam logic [1:0] KIND_CREATE  = 2'd0;
  localparam logic [1:0] KIND_DELETE  = 2'd1;
  localparam logic [1:0] KIND_CLEANUP = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_NO_FREE = 2'd2;

  localparam int KEY_INDEX_BITS  = 8;
  localparam int HANDLE_IN_BITS  = 32;
  localparam int SLOT_OUT_BITS   = 6;
  localparam int HANDLE_OUT_BITS = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FLUSH
  } walk_state_t;

  // Update request for the in-use bitmap.
  typedef struct packed {
    logic                     set;
    logic                     clr;
    logic [SLOT_OUT_BITS-1:0] idx;
  } map_upd_t;

endpackage

`default_nettype wire

// ===== rtl/kslot_handle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kslot_handle_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read, so a stalled consumer keeps it.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kslot_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kslot_map
  import kslot_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire map_upd_t                      upd,
  output logic [SLOT_COUNT-1:0]              in_use,
  output logic                               free_found,
  output logic [$clog2(SLOT_COUNT)-1:0]      free_idx
);

  localparam int AW = $clog2(SLOT_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      if (upd.set) begin
        in_use[upd.idx[AW-1:0]] <= 1'b1;
      end
      if (upd.clr) begin
        in_use[upd.idx[AW-1:0]] <= 1'b0;
      end
    end
  end

  // Lowest free slot: scanning downward leaves the lowest hit in place.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/key_slot_bitmap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Key slot allocator. Create, delete and unknown requests each return a single item
// from the output register; the next request is taken in the following cycle as
// long as the output register is free or being drained. A cleanup request walks the
// handle memory one slot at a time (read issue, then check of the registered read
// data) and keeps the block busy until its final item is loaded, also while the
// output side stalls. Matches leave in ascending slot order; one is always held back
// so that the final item can carry tlast. The in-use bitmap sits in flip-flops and
// is cleared by reset; handles live in a single-port-write, registered-read memory.
module key_slot_bitmap_allocator
  import kslot_pkg::*;
#(
  parameter int SLOT_COUNT  = 64,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // key_index[7:0], handler_handle[39:8]
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // slot_out[5:0], handler_out[37:6], zero[39:38]
  output logic [2:0]       m_tuser,   // status[1:0], entry_valid[2]
  output logic             m_tlast
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int CW = AW + 1;

  walk_state_t state, state_next;

  logic [1:0]                 in_kind;
  logic [KEY_INDEX_BITS-1:0]  in_key;
  logic [HANDLE_IN_BITS-1:0]  in_handle;
  logic [63:0]                in_h64;
  logic [HANDLE_BITS-1:0]     in_handle_w;

  logic [SLOT_COUNT-1:0]      in_use;
  logic                       free_found;
  logic [AW-1:0]              free_idx;
  map_upd_t                   upd;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [HANDLE_BITS-1:0]     ram_wdata;
  logic                       ram_re;
  logic [HANDLE_BITS-1:0]     rdata;

  logic [CW-1:0]              addr;
  logic [AW-1:0]              rd_slot;
  logic                       rd_live;
  logic                       walk_start;
  logic                       walk_step;

  logic                       pend_valid;
  logic [AW-1:0]              pend_slot;
  logic [HANDLE_BITS-1:0]     pend_handle;
  logic [63:0]                pend_h64;
  logic                       pend_load;
  logic                       pend_clear;

  logic [1:0]                 o_status;
  logic [SLOT_OUT_BITS-1:0]   o_slot;
  logic [HANDLE_OUT_BITS-1:0] o_handle;
  logic                       o_valid;
  logic                       o_last;

  logic                       out_load;
  logic [1:0]                 n_status;
  logic [SLOT_OUT_BITS-1:0]   n_slot;
  logic [HANDLE_OUT_BITS-1:0] n_handle;
  logic                       n_valid;
  logic                       n_last;

  logic                       out_free;
  logic                       accept;
  logic                       del_in_range;
  logic [AW-1:0]              del_idx;
  logic                       del_live;
  logic                       match;

  assign in_kind     = s_tuser;
  assign in_key      = s_tdata[7:0];
  assign in_handle   = s_tdata[39:8];
  assign in_h64      = 64'(in_handle);
  assign in_handle_w = in_h64[HANDLE_BITS-1:0];
  assign pend_h64    = 64'(pend_handle);

  assign out_free     = !m_tvalid || m_tready;
  assign accept       = s_tvalid && s_tready;
  assign del_in_range = in_key < KEY_INDEX_BITS'(SLOT_COUNT);
  assign del_idx      = in_key[AW-1:0];
  assign del_live     = del_in_range && in_use[del_idx];
  assign match        = rd_live && (rdata != '0);

  kslot_map #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .upd       (upd),
    .in_use    (in_use),
    .free_found(free_found),
    .free_idx  (free_idx)
  );

  // Writes happen only in idle and reads only during a walk, so the ports never collide.
  kslot_handle_ram #(
    .DEPTH(SLOT_COUNT),
    .WIDTH(HANDLE_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    n_status   = STATUS_OK;
    n_slot     = '0;
    n_handle   = '0;
    n_valid    = 1'b0;
    n_last     = 1'b1;
    upd        = '0;
    ram_we     = 1'b0;
    ram_waddr  = free_idx;
    ram_wdata  = in_handle_w;
    ram_re     = 1'b0;
    walk_start = 1'b0;
    walk_step  = 1'b0;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = out_free;
        if (accept) begin
          case (in_kind)
            KIND_CREATE: begin
              out_load = 1'b1;
              if (free_found) begin
                n_slot   = SLOT_OUT_BITS'(free_idx);
                n_valid  = 1'b1;
                upd.set  = 1'b1;
                upd.idx  = SLOT_OUT_BITS'(free_idx);
                ram_we   = 1'b1;
              end else begin
                n_status = STATUS_NO_FREE;
              end
            end
            KIND_DELETE: begin
              out_load = 1'b1;
              if (del_live) begin
                upd.clr   = 1'b1;
                upd.idx   = SLOT_OUT_BITS'(del_idx);
                ram_we    = 1'b1;
                ram_waddr = del_idx;
                ram_wdata = '0;
              end else begin
                n_status = STATUS_INVALID;
              end
            end
            KIND_CLEANUP: begin
              walk_start = 1'b1;
              state_next = S_READ;
            end
            default: begin
              out_load = 1'b1;
              n_status = STATUS_INVALID;
            end
          endcase
        end
      end
      S_READ: begin
        if (addr < CW'(SLOT_COUNT)) begin
          ram_re     = 1'b1;
          state_next = S_CHECK;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_CHECK: begin
        if (match) begin
          // A new match proves the held one is not the last, so it can go out now.
          if (pend_valid) begin
            if (out_free) begin
              out_load   = 1'b1;
              n_slot     = SLOT_OUT_BITS'(pend_slot);
              n_handle   = pend_h64[HANDLE_OUT_BITS-1:0];
              n_valid    = 1'b1;
              n_last     = 1'b0;
              pend_load  = 1'b1;
              walk_step  = 1'b1;
              state_next = S_READ;
            end
          end else begin
            pend_load  = 1'b1;
            walk_step  = 1'b1;
            state_next = S_READ;
          end
        end else begin
          walk_step  = 1'b1;
          state_next = S_READ;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          pend_clear = 1'b1;
          state_next = S_IDLE;
          if (pend_valid) begin
            n_slot   = SLOT_OUT_BITS'(pend_slot);
            n_handle = pend_h64[HANDLE_OUT_BITS-1:0];
            n_valid  = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (walk_start) begin
      addr <= '0;
    end else if (walk_step) begin
      addr <= addr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_slot <= addr[AW-1:0];
      rd_live <= in_use[addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_load) begin
      pend_valid <= 1'b1;
    end else if (pend_clear) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_slot   <= rd_slot;
      pend_handle <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status <= n_status;
      o_slot   <= n_slot;
      o_handle <= n_handle;
      o_valid  <= n_valid;
      o_last   <= n_last;
    end
  end

  assign m_tdata = {2'b00, o_handle, o_slot};
  assign m_tuser = {o_valid, o_status};
  assign m_tlast = o_last;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("pending cleanup entry left over in idle");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output item overwritten before it was taken");

  a_create_sets_bit: assert property (@(posedge clk) disable iff (rst)
    (accept && in_kind == KIND_CREATE && free_found) |=> in_use[$past(free_idx)])
    else $error("claimed slot not marked in use");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    addr <= CW'(SLOT_COUNT))
    else $error("cleanup walk ran past the last slot");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kslot_pkg::*;

  localparam int SLOTS = 64;
  localparam logic [1:0] KIND_UNDEFINED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  // A cleanup walk reads every slot in turn.
  localparam int TAIL_CYCLES = 2 * SLOTS + 12;
  localparam int DIRECTED_ITEMS = 20;
  localparam int ITEMS_PER_PHASE = 80;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] handler;
    logic        entry_valid;
    logic        last;
  } slot_result_t;

  typedef struct {
    logic [1:0]   kind;
    logic [7:0]   key_index;
    logic [31:0]  handle;
    bit           typed;
    slot_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // key_index[7:0], handler_handle[39:8]
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // slot_out[5:0], handler_out[37:6], zero[39:38]
  logic [2:0]  m_tuser;        // status[1:0], entry_valid[2]
  logic        m_tlast;

  key_slot_bitmap_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Shadow of the allocator state.
  logic [SLOTS-1:0] used_map = '0;
  logic [31:0]      handle_mem [SLOTS];

  slot_result_t due_results[$];
  int fails = 0;
  int items_sent = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  // Rows with typed results only where the answer is plain; the rest use the shadow.
  stim_row_t directed [DIRECTED_ITEMS] = '{
    '{KIND_CLEANUP,   8'h00, 32'h0000_0000, 1'b1, '{STATUS_OK, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_DELETE,    8'h00, 32'h0000_0000, 1'b1, '{STATUS_INVALID, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_DELETE,    8'hFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_INVALID, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_DELETE,    8'h40, 32'h0000_0000, 1'b1, '{STATUS_INVALID, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_UNDEFINED, 8'hAA, 32'h5555_5555, 1'b1, '{STATUS_INVALID, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_CREATE,    8'h00, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 6'd0, 32'd0, 1'b1, 1'b1}},
    '{KIND_CREATE,    8'hFF, 32'h0000_0000, 1'b1, '{STATUS_OK, 6'd1, 32'd0, 1'b1, 1'b1}},
    '{KIND_CREATE,    8'h00, 32'h0000_0001, 1'b1, '{STATUS_OK, 6'd2, 32'd0, 1'b1, 1'b1}},
    '{KIND_CLEANUP,   8'h00, 32'h0000_0000, 1'b0, '0},
    '{KIND_DELETE,    8'h01, 32'h0000_0000, 1'b1, '{STATUS_OK, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_DELETE,    8'h01, 32'h0000_0000, 1'b1, '{STATUS_INVALID, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_CREATE,    8'h00, 32'h8000_0000, 1'b1, '{STATUS_OK, 6'd1, 32'd0, 1'b1, 1'b1}},
    '{KIND_DELETE,    8'h3F, 32'h0000_0000, 1'b1, '{STATUS_INVALID, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_CREATE,    8'h00, 32'hA5A5_5A5A, 1'b1, '{STATUS_OK, 6'd3, 32'd0, 1'b1, 1'b1}},
    '{KIND_DELETE,    8'h00, 32'h0000_0000, 1'b1, '{STATUS_OK, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_CLEANUP,   8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{KIND_CREATE,    8'h00, 32'h0000_FFFF, 1'b1, '{STATUS_OK, 6'd0, 32'd0, 1'b1, 1'b1}},
    '{KIND_UNDEFINED, 8'h55, 32'hAAAA_AAAA, 1'b1, '{STATUS_INVALID, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_DELETE,    8'h80, 32'h0000_0000, 1'b1, '{STATUS_INVALID, 6'd0, 32'd0, 1'b0, 1'b1}},
    '{KIND_CLEANUP,   8'h00, 32'h0000_0000, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void compute_slot_results(input logic [1:0] kind,
                                               input logic [7:0] key_index,
                                               input logic [31:0] handle);
    slot_result_t r;
    int hits;
    hits = 0;
    r = '0;
    r.last = 1'b1;
    case (kind)
      KIND_CREATE: begin
        r.status = STATUS_NO_FREE;
        for (int s = 0; s < SLOTS; s++) begin
          if (hits == 0 && !used_map[s]) begin
            used_map[s] = 1'b1;
            handle_mem[s] = handle;
            r.status = STATUS_OK;
            r.slot = s[5:0];
            r.entry_valid = 1'b1;
            hits = 1;
          end
        end
        due_results.push_back(r);
      end
      KIND_DELETE: begin
        if (key_index < SLOTS && used_map[key_index[5:0]]) begin
          used_map[key_index[5:0]] = 1'b0;
          handle_mem[key_index[5:0]] = '0;
          r.status = STATUS_OK;
        end else begin
          r.status = STATUS_INVALID;
        end
        due_results.push_back(r);
      end
      KIND_CLEANUP: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (used_map[s] && handle_mem[s] != '0) begin
            due_results.push_back('{STATUS_OK, s[5:0], handle_mem[s], 1'b1, 1'b0});
            hits++;
          end
        end
        if (hits == 0) due_results.push_back(r);
        else due_results[due_results.size() - 1].last = 1'b1;
      end
      default: begin
        r.status = STATUS_INVALID;
        due_results.push_back(r);
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_handle();
    case ($urandom_range(7))
      0, 1: return 32'd0;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a slot that is in use, so deletes succeed and the map keeps moving.
  function automatic logic [7:0] delete_target();
    int pick;
    int start;
    logic [7:0] idx;
    pick = $urandom_range(9);
    start = $urandom_range(SLOTS - 1);
    idx = 8'($urandom_range(255));
    if (pick < 7 && used_map != '0) begin
      for (int k = SLOTS - 1; k >= 0; k--) begin
        if (used_map[(start + k) % SLOTS]) idx = 8'((start + k) % SLOTS);
      end
    end else if (pick == 9) begin
      idx = 8'($urandom_range(SLOTS - 1));
    end
    return idx;
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [7:0] key_index,
                              input logic [31:0] handle);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {handle, key_index};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    compute_slot_results(kind, key_index, handle);
    items_sent++;
  endtask

  task automatic run_episode(input bit fill_first);
    int mode;
    int n;
    int pick;
    mode = fill_first ? 0 : $urandom_range(5);
    if (mode == 0) begin
      // Fill the map, then poke at it while it is full.
      while (used_map != '1) send_request(KIND_CREATE, 8'($urandom_range(255)), rand_handle());
      n = $urandom_range(1, 3);
      if ($urandom_range(1) == 1) send_request(KIND_CLEANUP, 8'($urandom_range(255)), $urandom);
      repeat (n) send_request(KIND_CREATE, 8'($urandom_range(255)), rand_handle());
    end else if (mode == 1) begin
      n = $urandom_range(1, 40);
      repeat (n) send_request(KIND_DELETE, delete_target(), $urandom);
    end else begin
      repeat (12) begin
        pick = $urandom_range(99);
        if (pick < 40) send_request(KIND_CREATE, 8'($urandom_range(255)), rand_handle());
        else if (pick < 82) send_request(KIND_DELETE, delete_target(), $urandom);
        else if (pick < 96) send_request(KIND_CLEANUP, 8'($urandom_range(255)), $urandom);
        else send_request(KIND_UNDEFINED, 8'($urandom_range(255)), $urandom);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    slot_result_t want;
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $error("result item with nothing expected: slot_out 0x%0h, status 0x%0h",
               m_tdata[5:0], m_tuser[1:0]);
        fails++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser[1:0]));
        check_field("slot_out", 32'(want.slot), 32'(m_tdata[5:0]));
        check_field("handler_out", want.handler, m_tdata[37:6]);
        check_field("entry_valid", 32'(want.entry_valid), 32'(m_tuser[2]));
        check_field("last", 32'(want.last), 32'(m_tlast));
        check_field("tdata padding", 32'd0, 32'(m_tdata[39:38]));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      send_request(directed[i].kind, directed[i].key_index, directed[i].handle);
      if (directed[i].typed) begin
        void'(due_results.pop_back());
        due_results.push_back(directed[i].res);
      end
    end
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
        default: begin src_idle_pct = 6; sink_stall_pct = 6; end
      endcase
      run_episode(1'b1);
      while (items_sent < DIRECTED_ITEMS + (phase + 1) * ITEMS_PER_PHASE) run_episode(1'b0);
      // Hold the input off until every outstanding result has drained.
      s_tvalid <= 1'b0;
      do @(posedge clk); while (due_results.size() != 0);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
